[rtl/hps_pkg.sv]
// ----------------------------------------------------------------------------
// hps_pkg: shared types and constants for the pulse speed meter
// Payload structs, action codes, sequencer states and fixed constants.
// ----------------------------------------------------------------------------
package hps_pkg;

  typedef enum logic [1:0] {
    ACT_PULSE  = 2'd0,
    ACT_INDEX  = 2'd1,
    ACT_CALREQ = 2'd2,
    ACT_STATUS = 2'd3
  } action_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] timestamp_us;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  sector;
    logic [31:0] period_us;
    logic        interval_valid;
    logic [31:0] rpm_q8;
    logic [31:0] rad_s_q8;
    logic        calibrating;
    logic        cal_done;
  } out_item_t;

  localparam logic [15:0] FACTOR_ONE = 16'd25600;
  localparam logic [19:0] RPM_NUM    = 20'd600000;
  localparam logic [35:0] RAD_NUM    = 36'd62831853072;
  localparam logic [19:0] RAD_DEN    = 20'd1000000;

  localparam int REG_DIR = 0;
  localparam int REG_LUT = 1;

  typedef enum logic [3:0] {
    ST_IDLE,    // waiting for an item
    ST_CLEAR,   // clearing sample memory
    ST_SCAN,    // reading samples of one sector
    ST_SACC,    // accumulate one sample
    ST_SEND,    // finish one sector
    ST_FCALC,   // factor division setup
    ST_FDIV,    // factor division
    ST_FWR,     // factor write
    ST_SPD,     // setup speed divisions
    ST_DIV,     // running divider
    ST_OUT      // result waiting for transfer
  } state_t;

  // Restoring divider control.
  typedef struct packed {
    logic start;
  } div_ctl_t;

endpackage

[rtl/hps_div.sv]
// ----------------------------------------------------------------------------
// hps_div: serial restoring divider
// One quotient bit per cycle; 64-bit numerator, 64-bit denominator.
// ----------------------------------------------------------------------------
module hps_div
  import hps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  div_ctl_t    ctl,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        busy,
  output logic [63:0] quo
);

  logic [63:0] rem_r, rem_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [63:0] den_r, den_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [64:0] trial;

  // The operands are only presented in the start cycle, so the divisor is held.
  assign trial = {rem_r, quo_r[63]};
  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    if (ctl.start) begin
      rem_nxt = '0;
      quo_nxt = num;
      den_nxt = den;
      cnt_nxt = 7'd64;
    end else if (cnt_r != 7'd0) begin
      cnt_nxt = cnt_r - 7'd1;
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = 64'(trial - {1'b0, den_r});
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial[63:0];
        quo_nxt = {quo_r[62:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    if (!rst_n) cnt_r <= '0;
    else cnt_r <= cnt_nxt;
  end

  assign busy = (cnt_r != 7'd0);
  assign quo  = quo_r;

endmodule

[rtl/hall_pulse_speed_with_sector_lut_unit.sv]
// ----------------------------------------------------------------------------
// hall_pulse_speed_with_sector_lut_unit: encoder period speed meter
// Pulse interval, sector tracking, calibration and corrected rpm / rad/s.
// ----------------------------------------------------------------------------
// Each item runs two serial divisions (rpm, then rad/s) before its result is
// offered; no new item is taken until that result is transferred.
// An index edge that starts calibration first clears all PULSES*CAL_REVS
// sample entries; one that completes it first scans the CAL_REVS samples and
// runs one factor division for each sector.
// Reset is synchronous and active low; the factor table resets to 100%.
module hall_pulse_speed_with_sector_lut_unit
  import hps_pkg::*;
#(
  parameter int PULSES   = 15,
  parameter int CAL_REVS = 15
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [0:0] cfg_wdata
);

  localparam int SW   = (PULSES > 1) ? $clog2(PULSES) : 1;
  localparam int RW   = $clog2(CAL_REVS + 1);
  localparam int DEP  = PULSES * CAL_REVS;
  localparam int AW   = $clog2(DEP);
  localparam int FDEP = PULSES * 2;
  localparam int FW   = $clog2(FDEP);

  state_t state_r, state_nxt;

  logic dir_r, lut_r;
  logic [31:0] last_time_r;
  logic have_last_r, have_iv_r;
  logic [31:0] last_iv_r;
  logic [SW-1:0] sec_r;
  logic cal_pend_r, cal_act_r;
  logic [6:0] rev_r;
  logic done_r;

  // Sample memory.
  logic [31:0] smem [DEP];
  logic        sm_we;
  logic [AW-1:0] sm_wa, sm_ra;
  logic [31:0] sm_wd, sm_rd_r;

  // Factor table with valid bits (invalid reads as 100 percent).
  logic [15:0] ftab_r [FDEP];
  logic [FDEP-1:0] fvalid_r;

  // Calibration sweep registers.
  logic [AW-1:0] addr_r;
  logic [SW-1:0] cs_r;
  logic [RW-1:0] cr_r;
  logic [31:0] lo_r, hi_r;
  logic [37:0] acc_r;
  logic [6:0]  cnt_r;
  logic [37:0] trim_r [PULSES];
  logic [PULSES-1:0] filled_r;
  logic [43:0] total_r;
  logic        spd_phase_r;
  logic [31:0] rpm_r;
  logic [15:0] f_r;

  div_ctl_t dctl;
  logic [63:0] dnum, dden, dquo;
  logic dbusy;

  hps_div u_div (.clk, .rst_n, .ctl(dctl), .num(dnum), .den(dden),
                 .busy(dbusy), .quo(dquo));

  in_item_t it;
  assign it = in_data;
  logic accept;
  assign accept = in_valid && in_ready;

  logic [SW-1:0] prev_sec;
  assign prev_sec = (sec_r == '0) ? SW'(PULSES - 1) : sec_r - SW'(1);

  logic [FW-1:0] fidx;
  assign fidx = FW'({prev_sec, 1'b0}) + FW'(dir_r);
  logic [15:0] fsel;
  assign fsel = !lut_r ? FACTOR_ONE : (fvalid_r[fidx] ? ftab_r[fidx] : FACTOR_ONE);
  // The first speed step reads the settled table; the second reuses that factor.
  logic [15:0] f_cur;
  assign f_cur = spd_phase_r ? f_r : fsel;

  logic spd_zero;
  assign spd_zero = !have_iv_r || (last_iv_r == '0) || (f_r == '0);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) begin
        if (it.action == ACT_INDEX && cal_pend_r && !cal_act_r) state_nxt = ST_CLEAR;
        else if (it.action == ACT_INDEX && cal_act_r && rev_r + 7'd1 >= 7'(CAL_REVS))
          state_nxt = ST_SCAN;
        else state_nxt = ST_SPD;
      end
      ST_CLEAR: if (addr_r == AW'(DEP - 1)) state_nxt = ST_SPD;
      ST_SCAN:  state_nxt = ST_SACC;
      ST_SACC:  state_nxt = (cr_r == RW'(CAL_REVS - 1)) ? ST_SEND : ST_SCAN;
      ST_SEND:  state_nxt = (cs_r == SW'(PULSES - 1)) ? ST_FCALC : ST_SCAN;
      ST_FCALC: state_nxt = ST_FDIV;
      ST_FDIV:  if (!dbusy) state_nxt = ST_FWR;
      ST_FWR:   state_nxt = (cs_r == SW'(PULSES - 1)) ? ST_SPD : ST_FCALC;
      ST_SPD:   state_nxt = ST_DIV;
      ST_DIV:   if (!dbusy) state_nxt = spd_phase_r ? ST_OUT : ST_SPD;
      ST_OUT:   if (out_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and divider operands.
  logic [63:0] fnum;
  logic [37:0] trim_cur;
  assign trim_cur = trim_r[cs_r];
  assign fnum = 64'(trim_cur) * 64'(25600 * PULSES);
  always_comb begin
    in_ready = (state_r == ST_IDLE);
    out_valid = (state_r == ST_OUT);
    dctl.start = 1'b0;
    dnum = '0;
    dden = 64'd1;
    unique case (state_r)
      ST_FCALC: begin
        dctl.start = 1'b1;
        dnum = fnum + 64'(total_r >> 1);
        dden = (total_r == '0) ? 64'd1 : 64'(total_r);
      end
      ST_SPD: begin
        dctl.start = 1'b1;
        if (!spd_phase_r) begin
          dnum = 64'(RPM_NUM) * 64'(f_cur) + ((64'(PULSES) * 64'(last_iv_r)) >> 1);
          dden = 64'(PULSES) * 64'(last_iv_r);
        end else begin
          dnum = 64'(RAD_NUM) * 64'(f_cur)
               + ((64'(RAD_DEN) * 64'(PULSES) * 64'(last_iv_r)) >> 1);
          dden = 64'(RAD_DEN) * 64'(PULSES) * 64'(last_iv_r);
        end
        if (dden == '0) dden = 64'd1;
      end
      default: ;
    endcase
  end

  // Sample memory write-port control.
  always_comb begin
    sm_we = 1'b0;
    sm_wa = '0;
    sm_wd = '0;
    if (state_r == ST_CLEAR) begin
      sm_we = 1'b1;
      sm_wa = addr_r;
    end else if (accept && it.action == ACT_PULSE && have_last_r && cal_act_r
                 && rev_r < 7'(CAL_REVS)) begin
      sm_we = 1'b1;
      sm_wa = AW'(32'(sec_r) * CAL_REVS + 32'(rev_r));
      sm_wd = it.timestamp_us - last_time_r;
    end
  end
  assign sm_ra = AW'(32'(cs_r) * CAL_REVS + 32'(cr_r));

  always_ff @(posedge clk) begin
    if (sm_we) smem[sm_wa] <= sm_wd;
    sm_rd_r <= smem[sm_ra];
  end

  logic [15:0] fsat;
  assign fsat = (dquo > 64'd65535) ? 16'hFFFF : dquo[15:0];
  logic [31:0] qsat;
  assign qsat = (dquo > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : dquo[31:0];
  logic [FW-1:0] fwidx;
  assign fwidx = FW'({cs_r, 1'b0}) + FW'(dir_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      dir_r <= 1'b0; lut_r <= 1'b0;
      last_time_r <= '0; have_last_r <= 1'b0; have_iv_r <= 1'b0;
      last_iv_r <= '0; sec_r <= '0; cal_pend_r <= 1'b0; cal_act_r <= 1'b0;
      rev_r <= '0; done_r <= 1'b0; fvalid_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        if (cfg_index == 1'(REG_DIR)) dir_r <= cfg_wdata[0];
        else lut_r <= cfg_wdata[0];
      end
      if (accept) begin
        done_r <= 1'b0;
        spd_phase_r <= 1'b0;
        addr_r <= '0; cs_r <= '0; cr_r <= '0;
        lo_r <= '1; hi_r <= '0; acc_r <= '0; cnt_r <= '0; total_r <= '0;
        unique case (action_t'(it.action))
          ACT_PULSE: begin
            if (have_last_r) begin
              last_iv_r <= it.timestamp_us - last_time_r;
              have_iv_r <= 1'b1;
            end
            have_last_r <= 1'b1;
            last_time_r <= it.timestamp_us;
            sec_r <= (sec_r == SW'(PULSES - 1)) ? '0 : sec_r + SW'(1);
          end
          ACT_INDEX: begin
            sec_r <= '0;
            if (cal_pend_r && !cal_act_r) begin
              cal_act_r <= 1'b1; cal_pend_r <= 1'b0; rev_r <= '0;
            end else if (cal_act_r) begin
              rev_r <= rev_r + 7'd1;
              if (rev_r + 7'd1 >= 7'(CAL_REVS)) done_r <= 1'b1;
            end
          end
          ACT_CALREQ: cal_pend_r <= 1'b1;
          ACT_STATUS: ;
          default: ;
        endcase
      end
      unique case (state_r)
        ST_CLEAR: addr_r <= addr_r + AW'(1);
        ST_SACC: begin
          if (sm_rd_r != '0) begin
            cnt_r <= cnt_r + 7'd1;
            acc_r <= acc_r + 38'(sm_rd_r);
            if (sm_rd_r < lo_r) lo_r <= sm_rd_r;
            if (sm_rd_r > hi_r) hi_r <= sm_rd_r;
          end
          cr_r <= cr_r + RW'(1);
        end
        ST_SEND: begin
          filled_r[cs_r] <= (cnt_r != '0);
          if (cnt_r >= 7'd2) begin
            trim_r[cs_r] <= acc_r - 38'(lo_r) - 38'(hi_r);
            total_r <= total_r + 44'(acc_r - 38'(lo_r) - 38'(hi_r));
          end else trim_r[cs_r] <= '0;
          cr_r <= '0; lo_r <= '1; hi_r <= '0; acc_r <= '0; cnt_r <= '0;
          cs_r <= (cs_r == SW'(PULSES - 1)) ? '0 : cs_r + SW'(1);
        end
        ST_FWR: begin
          ftab_r[fwidx] <= (!filled_r[cs_r] || total_r == '0) ? FACTOR_ONE : fsat;
          fvalid_r[fwidx] <= 1'b1;
          cs_r <= cs_r + SW'(1);
          if (cs_r == SW'(PULSES - 1)) begin
            cal_act_r <= 1'b0; rev_r <= '0;
          end
        end
        ST_DIV: if (!dbusy) begin
          if (!spd_phase_r) rpm_r <= spd_zero ? '0 : qsat;
          spd_phase_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Factor sampled in the first speed step, once the table and sector are final.
  always_ff @(posedge clk) begin
    if (state_r == ST_SPD && !spd_phase_r) f_r <= fsel;
  end

  logic [31:0] rad_r;
  always_ff @(posedge clk) begin
    if (state_r == ST_DIV && !dbusy && spd_phase_r) rad_r <= spd_zero ? '0 : qsat;
  end

  always_comb begin
    out_data.sector = 6'(sec_r);
    out_data.period_us = last_iv_r;
    out_data.interval_valid = have_iv_r;
    out_data.rpm_q8 = rpm_r;
    out_data.rad_s_q8 = rad_r;
    out_data.calibrating = cal_act_r;
    out_data.cal_done = done_r;
  end

endmodule

[rtl/hps_checker.sv]
// ----------------------------------------------------------------------------
// hps_checker: port-level checks for the pulse speed meter
// Watches handshakes and result fields over time.
// ----------------------------------------------------------------------------
module hps_checker
  import hps_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // No new transfer is taken while a result waits.
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !in_ready)
    else $error("input taken while result pending");

  // An offered input stays offered until its transfer.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid)
    else $error("input withdrawn before transfer");

  // A waiting result keeps its value.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result changed while stalled");

  // Speed is zero without a valid interval.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.interval_valid |-> out_data.rpm_q8 == '0)
    else $error("speed without interval");

  // Completion clears the calibrating flag.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.cal_done |-> !out_data.calibrating)
    else $error("calibration done but still running");

endmodule

bind hall_pulse_speed_with_sector_lut_unit hps_checker u_hps_checker (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);
